// ----- rtl/mteq_pkg.sv -----
// Shared types and constants of the timer expiry queue.
package mteq_pkg;

  localparam int unsigned MaxResults = 16;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] timer_id;
    logic [47:0] deadline;
    logic [31:0] interval;
    logic [47:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic        fired;
    logic [15:0] expired_id;
    logic        last;
    logic        earliest_changed;
    logic        arm_valid;
    logic [47:0] arm_delay;
    logic [1:0]  status;
  } out_item_t;

  // One slot of the timer table as held in RAM.
  typedef struct packed {
    logic [15:0] ident;
    logic [31:0] interval;
    logic [47:0] deadline;
  } slot_t;

  typedef struct packed {
    logic latch;
    logic scan_start;
    logic commit;
    logic emit_pend;
    logic emit_final;
  } ctl_cmd_t;

  typedef struct packed {
    logic       scan_busy;
    logic       out_free;
    logic       pick_found;
    logic       pend_vld;
    logic [1:0] kind;
  } dp_stat_t;

endpackage

// ----- rtl/mteq_ram.sv -----
// Generic single-port-write, registered-read RAM.
module mteq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/mteq_datapath.sv -----
// Datapath: slot table, scan trackers, commit logic and output register.
module mteq_datapath #(
  parameter int unsigned TIMER_SLOTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mteq_pkg::in_item_t  in_item_i,
  input  logic                cfg_we_i,
  input  logic [19:0]         cfg_data_i,
  input  mteq_pkg::ctl_cmd_t  cmd_i,
  output mteq_pkg::dp_stat_t  stat_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output mteq_pkg::out_item_t out_item_o
);
  import mteq_pkg::*;

  localparam int unsigned IW = $clog2(TIMER_SLOTS);
  localparam logic [IW-1:0] LastIdx = IW'(TIMER_SLOTS - 1);
  localparam int unsigned SW = $bits(slot_t);

  in_item_t                item_q;
  logic [19:0]             min_delay_q;
  logic [TIMER_SLOTS-1:0]  used_q;

  // scan
  logic          scanning_q;
  logic [IW-1:0] rd_idx_q;
  logic          cmp_vld_q;
  logic [IW-1:0] cmp_idx_q;
  slot_t         cur;
  logic          cur_used;
  logic [SW-1:0] ram_rdata;

  // trackers
  logic          exp_vld_q, all_vld_q, hit_vld_q, free_vld_q;
  slot_t         exp_q;
  logic [IW-1:0] exp_idx_q, hit_idx_q, free_idx_q;
  logic [47:0]   all_dl_q, hit_dl_q;
  logic          exp_take, all_take, hit_take, free_take;

  // pending tick result
  logic          pend_vld_q;
  logic [15:0]   pend_id_q;

  // writes
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  slot_t         ram_wdata;
  logic [48:0]   reload_sum;
  logic [47:0]   reload_dl;

  // output
  logic          out_valid_q;
  out_item_t     out_q;
  out_item_t     final_item;
  logic          out_free;
  logic [47:0]   tgt, diff, min_ext, delay;
  logic          ec;

  assign cur      = slot_t'(ram_rdata);
  assign cur_used = used_q[cmp_idx_q];

  assign exp_take = cmp_vld_q && cur_used && (cur.deadline < item_q.now_time) &&
                    (!exp_vld_q || cur.deadline < exp_q.deadline);
  assign all_take = cmp_vld_q && cur_used && (!all_vld_q || cur.deadline < all_dl_q);
  assign hit_take = cmp_vld_q && cur_used && (cur.ident == item_q.timer_id) &&
                    (!hit_vld_q || cur.deadline < hit_dl_q);
  assign free_take = cmp_vld_q && !cur_used && !free_vld_q;

  mteq_ram #(.WIDTH(SW), .DEPTH(TIMER_SLOTS)) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (scanning_q),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  // saturating reload: now + interval
  assign reload_sum = {1'b0, item_q.now_time} + {17'b0, exp_q.interval};
  assign reload_dl  = reload_sum[48] ? '1 : reload_sum[47:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = free_idx_q;
    ram_wdata = '{ident: item_q.timer_id, interval: item_q.interval,
                  deadline: item_q.deadline};
    if (cmd_i.commit) begin
      if (item_q.kind == KIND_ADD && free_vld_q) begin
        ram_we = 1'b1;
      end else if (item_q.kind == KIND_TICK && exp_vld_q && exp_q.interval != '0) begin
        ram_we    = 1'b1;
        ram_waddr = exp_idx_q;
        ram_wdata = '{ident: exp_q.ident, interval: exp_q.interval, deadline: reload_dl};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_delay_q <= 20'd100;
      used_q      <= '0;
      scanning_q  <= 1'b0;
      rd_idx_q    <= '0;
      cmp_vld_q   <= 1'b0;
      exp_vld_q   <= 1'b0;
      all_vld_q   <= 1'b0;
      hit_vld_q   <= 1'b0;
      free_vld_q  <= 1'b0;
      pend_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        min_delay_q <= cfg_data_i;
      end
      if (cmd_i.latch) begin
        pend_vld_q <= 1'b0;
      end

      // read one slot per cycle, compare it in the next cycle
      cmp_vld_q <= scanning_q;
      if (cmd_i.scan_start) begin
        scanning_q <= 1'b1;
        rd_idx_q   <= '0;
        exp_vld_q  <= 1'b0;
        all_vld_q  <= 1'b0;
        hit_vld_q  <= 1'b0;
        free_vld_q <= 1'b0;
      end else begin
        if (scanning_q) begin
          rd_idx_q <= rd_idx_q + 1'b1;
          if (rd_idx_q == LastIdx) begin
            scanning_q <= 1'b0;
          end
        end
        if (exp_take)  exp_vld_q  <= 1'b1;
        if (all_take)  all_vld_q  <= 1'b1;
        if (hit_take)  hit_vld_q  <= 1'b1;
        if (free_take) free_vld_q <= 1'b1;
      end

      if (cmd_i.commit) begin
        case (item_q.kind)
          KIND_ADD: begin
            if (free_vld_q) used_q[free_idx_q] <= 1'b1;
          end
          KIND_CANCEL: begin
            if (hit_vld_q) used_q[hit_idx_q] <= 1'b0;
          end
          KIND_TICK: begin
            if (exp_vld_q) begin
              pend_vld_q <= 1'b1;
              if (exp_q.interval == '0) used_q[exp_idx_q] <= 1'b0;
            end
          end
          default: ;
        endcase
      end

      if (cmd_i.emit_pend || cmd_i.emit_final) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) item_q <= in_item_i;
    if (exp_take) begin
      exp_q     <= cur;
      exp_idx_q <= cmp_idx_q;
    end
    if (all_take) all_dl_q <= cur.deadline;
    if (hit_take) begin
      hit_dl_q  <= cur.deadline;
      hit_idx_q <= cmp_idx_q;
    end
    if (free_take) free_idx_q <= cmp_idx_q;
    cmp_idx_q <= rd_idx_q;
    if (cmd_i.commit && item_q.kind == KIND_TICK) pend_id_q <= exp_q.ident;
    if (cmd_i.emit_pend) begin
      out_q <= '{fired: 1'b1, expired_id: pend_id_q, last: 1'b0,
                 earliest_changed: 1'b0, arm_valid: 1'b0, arm_delay: '0, status: ST_OK};
    end else if (cmd_i.emit_final) begin
      out_q <= final_item;
    end
  end

  // alarm delay: max(target - now, min_arm_delay)
  assign tgt     = (item_q.kind == KIND_ADD) ? item_q.deadline : all_dl_q;
  assign diff    = (tgt > item_q.now_time) ? tgt - item_q.now_time : '0;
  assign min_ext = {28'b0, min_delay_q};
  assign delay   = (diff < min_ext) ? min_ext : diff;
  assign ec      = !all_vld_q || (item_q.deadline < all_dl_q);

  always_comb begin
    final_item      = '0;
    final_item.last = 1'b1;
    case (item_q.kind)
      KIND_ADD: begin
        if (!free_vld_q) begin
          final_item.status = ST_FULL;
        end else begin
          final_item.earliest_changed = ec;
          final_item.arm_valid        = ec;
          final_item.arm_delay        = ec ? delay : '0;
        end
      end
      KIND_CANCEL: begin
        final_item.status = hit_vld_q ? ST_OK : ST_NOT_FOUND;
      end
      KIND_TICK: begin
        final_item.fired      = pend_vld_q;
        final_item.expired_id = pend_vld_q ? pend_id_q : '0;
        final_item.arm_valid  = all_vld_q;
        final_item.arm_delay  = all_vld_q ? delay : '0;
      end
      default: ;
    endcase
  end

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign stat_o = '{scan_busy: scanning_q | cmp_vld_q, out_free: out_free,
                    pick_found: exp_vld_q, pend_vld: pend_vld_q, kind: item_q.kind};

endmodule

// ----- rtl/mteq_ctrl.sv -----
// Controller: sequences scans, commits and result emission per item.
module mteq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mteq_pkg::dp_stat_t stat_i,
  output mteq_pkg::ctl_cmd_t cmd_o
);
  import mteq_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  logic [1:0] state_q, state_d;
  logic [4:0] n_q, n_d;
  logic       more;

  // another expired timer to take on this tick
  assign more = (stat_i.kind == KIND_TICK) && stat_i.pick_found &&
                (n_q != 5'(MaxResults));

  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch      = 1'b1;
          cmd_o.scan_start = 1'b1;
          n_d              = '0;
          state_d          = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stat_i.scan_busy) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat_i.out_free) begin
          if (more) begin
            cmd_o.commit     = 1'b1;
            cmd_o.emit_pend  = stat_i.pend_vld;
            cmd_o.scan_start = 1'b1;
            n_d              = n_q + 5'd1;
            state_d          = S_SCAN;
          end else begin
            cmd_o.commit     = (stat_i.kind != KIND_TICK);
            cmd_o.emit_final = 1'b1;
            state_d          = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
    end
  end

  a_pend_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_pend |-> stat_i.pend_vld)
    else $error("pending result emitted without a pending timer");

  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_pend || cmd_o.emit_final) |-> stat_i.out_free)
    else $error("result loaded into a full output register");

  a_tick_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= 5'(MaxResults))
    else $error("tick expired more timers than allowed");

endmodule

// ----- rtl/multi_timer_expiry_queue.sv -----
// Top level of the deadline-ordered timer expiry queue.
// A table of TIMER_SLOTS timers (id, 48-bit deadline, 32-bit reload interval)
// held in a RAM with one used flag per slot. Every item triggers a scan that
// reads one slot per cycle through the RAM's single read port; an add, cancel
// or unused kind takes one scan and then waits for room in the output register
// before the next item is taken. A tick repeats that scan once per expired
// timer (at most 16) plus a final scan; each scan picks the earliest expired
// timer by (deadline, slot), which is then reloaded to now + interval
// (saturating) or freed.
// Results leave through an output register, so the next item is taken while
// the last result of the previous one still waits. The alarm delay reported
// is the time to the earliest deadline, never below min_arm_delay (reset 100).
module multi_timer_expiry_queue #(
  parameter int unsigned TIMER_SLOTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mteq_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mteq_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [19:0]         cfg_data_i
);
  import mteq_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // sequencing: scan, decide, commit, emit
  mteq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // table, trackers and output register
  mteq_datapath #(.TIMER_SLOTS(TIMER_SLOTS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- bench/tb_multi_timer_expiry_queue.sv -----
// Self-checking testbench of the deadline-ordered timer expiry queue.
`timescale 1ns / 100ps

module tb_multi_timer_expiry_queue;
  import mteq_pkg::*;

  localparam int unsigned SLOTS = 16;
  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_we_i = 1'b0;
  logic [19:0] cfg_data_i = '0;

  multi_timer_expiry_queue #(.TIMER_SLOTS(SLOTS)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o),
    .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the timer table.
  logic [47:0] tmr_deadline [SLOTS];
  logic [31:0] tmr_interval [SLOTS];
  logic [15:0] tmr_ident [SLOTS];
  logic        tmr_used [SLOTS];
  logic [19:0] arm_floor;

  out_item_t   expected_q[$];
  int          fail_count = 0;
  int unsigned idle_cycles = 0;
  int          stall_hold = 0;

  function automatic bit precedes(int a, int b);
    if (tmr_deadline[a] != tmr_deadline[b]) return tmr_deadline[a] < tmr_deadline[b];
    return a < b;
  endfunction

  function automatic int first_slot();
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++)
      if (tmr_used[i] && (best < 0 || precedes(i, best))) best = i;
    return best;
  endfunction

  function automatic logic [47:0] alarm_delay(logic [47:0] target, logic [47:0] now);
    logic [47:0] d;
    d = (target > now) ? target - now : 48'd0;
    if (d < {28'd0, arm_floor}) d = {28'd0, arm_floor};
    return d;
  endfunction

  // Applies one item to the shadow table and queues the results it causes.
  task automatic predict_timers(in_item_t it);
    out_item_t r;
    int        slot;
    int        first;
    int        order[$];
    bit        taken[SLOTS];
    logic [48:0] sum;
    r = '0;
    r.last = 1'b1;
    case (it.kind)
      KIND_ADD: begin
        slot = -1;
        for (int i = SLOTS - 1; i >= 0; i--) if (!tmr_used[i]) slot = i;
        if (slot < 0) begin
          r.status = ST_FULL;
        end else begin
          first = first_slot();
          r.earliest_changed = (first < 0) || (it.deadline < tmr_deadline[first]);
          r.arm_valid = r.earliest_changed;
          if (r.arm_valid) r.arm_delay = alarm_delay(it.deadline, it.now_time);
          tmr_deadline[slot] = it.deadline;
          tmr_interval[slot] = it.interval;
          tmr_ident[slot] = it.timer_id;
          tmr_used[slot] = 1'b1;
        end
        expected_q.push_back(r);
      end
      KIND_CANCEL: begin
        slot = -1;
        for (int i = 0; i < SLOTS; i++)
          if (tmr_used[i] && tmr_ident[i] == it.timer_id && (slot < 0 || precedes(i, slot)))
            slot = i;
        if (slot < 0) r.status = ST_NOT_FOUND;
        else tmr_used[slot] = 1'b0;
        expected_q.push_back(r);
      end
      KIND_TICK: begin
        for (int i = 0; i < SLOTS; i++) taken[i] = 1'b0;
        while (order.size() < MaxResults) begin
          slot = -1;
          for (int i = 0; i < SLOTS; i++)
            if (tmr_used[i] && !taken[i] && tmr_deadline[i] < it.now_time &&
                (slot < 0 || precedes(i, slot)))
              slot = i;
          if (slot < 0) break;
          taken[slot] = 1'b1;
          order.push_back(slot);
        end
        foreach (order[k]) begin
          if (tmr_interval[order[k]] != 0) begin
            sum = {1'b0, it.now_time} + {17'd0, tmr_interval[order[k]]};
            tmr_deadline[order[k]] = sum[48] ? TIME_MAX : sum[47:0];
          end else begin
            tmr_used[order[k]] = 1'b0;
          end
        end
        first = first_slot();
        foreach (order[k]) begin
          r = '0;
          r.fired = 1'b1;
          r.expired_id = tmr_ident[order[k]];
          r.last = (k == order.size() - 1);
          if (r.last && first >= 0) begin
            r.arm_valid = 1'b1;
            r.arm_delay = alarm_delay(tmr_deadline[first], it.now_time);
          end
          expected_q.push_back(r);
        end
        if (order.size() == 0) begin
          r = '0;
          r.last = 1'b1;
          if (first >= 0) begin
            r.arm_valid = 1'b1;
            r.arm_delay = alarm_delay(tmr_deadline[first], it.now_time);
          end
          expected_q.push_back(r);
        end
      end
      default: expected_q.push_back(r);
    endcase
  endtask

  // Result checker and output stall generator.
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result %p", out_item_o);
        fail_count++;
      end else begin
        e = expected_q.pop_front();
        if (out_item_o.fired !== e.fired) begin
          $error("fired exp %0d got %0d", e.fired, out_item_o.fired); fail_count++;
        end
        if (out_item_o.expired_id !== e.expired_id) begin
          $error("expired_id exp %0d got %0d", e.expired_id, out_item_o.expired_id);
          fail_count++;
        end
        if (out_item_o.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_item_o.last); fail_count++;
        end
        if (out_item_o.earliest_changed !== e.earliest_changed) begin
          $error("earliest_changed exp %0d got %0d", e.earliest_changed,
                 out_item_o.earliest_changed);
          fail_count++;
        end
        if (out_item_o.arm_valid !== e.arm_valid) begin
          $error("arm_valid exp %0d got %0d", e.arm_valid, out_item_o.arm_valid);
          fail_count++;
        end
        if (out_item_o.arm_delay !== e.arm_delay) begin
          $error("arm_delay exp %0d got %0d", e.arm_delay, out_item_o.arm_delay);
          fail_count++;
        end
        if (out_item_o.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_item_o.status); fail_count++;
        end
      end
    end
    // mostly free-flowing, with short stalls and an occasional long one
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if ($urandom_range(0, 49) == 0) begin
      out_stall_i <= 1'b1;
      stall_hold  <= $urandom_range(10, 40);
    end else if ($urandom_range(0, 9) < 3) out_stall_i <= 1'b1;
    else if ($urandom_range(0, 1)) out_stall_i <= 1'b0;
  end

  // Watchdog: cycles with no item moving on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL multi_timer_expiry_queue");
      $finish;
    end
  end

  // valid stays up after acceptance; the next item or a gap takes it over
  task automatic send_item(in_item_t it);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    predict_timers(it);
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if (n != 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic set_arm_floor(logic [19:0] v);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    arm_floor = v;
  endtask

  // Directed rows; a nonzero check flag compares against the typed result too.
  typedef struct {
    in_item_t  it;
    bit        has_ref;
    out_item_t ref_res;
  } row_t;

  row_t      rows[$];
  logic [47:0] clock_now;

  function automatic in_item_t mk(logic [1:0] k, logic [15:0] id, logic [47:0] dl,
                                  logic [31:0] iv, logic [47:0] now);
    in_item_t it;
    it.kind = k; it.timer_id = id; it.deadline = dl; it.interval = iv; it.now_time = now;
    return it;
  endfunction

  function automatic out_item_t res(logic ec, logic av, logic [47:0] d, logic [1:0] st);
    out_item_t r;
    r = '0;
    r.last = 1'b1; r.earliest_changed = ec; r.arm_valid = av; r.arm_delay = d;
    r.status = st;
    return r;
  endfunction

  initial begin
    in_item_t it;
    int       pick;
    for (int i = 0; i < SLOTS; i++) begin
      tmr_deadline[i] = '0; tmr_interval[i] = '0; tmr_ident[i] = '0; tmr_used[i] = 1'b0;
    end
    arm_floor = 20'd100;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset: empty tick, unknown cancel, unused kind, first add
    rows.push_back('{mk(KIND_TICK, 0, 0, 0, 1000), 1, res(0, 0, 0, ST_OK)});
    rows.push_back('{mk(KIND_CANCEL, 16'hFFFF, 0, 0, 0), 1, res(0, 0, 0, ST_NOT_FOUND)});
    rows.push_back('{mk(2'd3, 16'hFFFF, TIME_MAX, 32'hFFFF_FFFF, TIME_MAX), 1,
                     res(0, 0, 0, ST_OK)});
    rows.push_back('{mk(KIND_ADD, 16'h0001, 48'd5000, 0, 48'd1000), 1,
                     res(1, 1, 48'd4000, ST_OK)});
    // earlier deadline than now: delay clamps to the floor
    rows.push_back('{mk(KIND_ADD, 16'h0002, 48'd10, 32'd300, 48'd1000), 1,
                     res(1, 1, 48'd100, ST_OK)});
    rows.push_back('{mk(KIND_ADD, 16'hFFFF, TIME_MAX, 32'hFFFF_FFFF, 0), 1,
                     res(0, 0, 0, ST_OK)});
    // equal deadline ties and duplicate ids
    rows.push_back('{mk(KIND_ADD, 16'h0002, 48'd10, 0, 48'd1000), 0, '0});
    rows.push_back('{mk(KIND_ADD, 16'h0003, 48'd4000, 32'hFFFF_FFFF, 48'd1000), 0, '0});
    rows.push_back('{mk(KIND_CANCEL, 16'h0002, 0, 0, 48'd1000), 1, res(0, 0, 0, ST_OK)});
    rows.push_back('{mk(KIND_TICK, 0, 0, 0, 48'd4500), 0, '0});
    // reload saturation near the top of time
    rows.push_back('{mk(KIND_TICK, 0, 0, 0, TIME_MAX), 0, '0});
    // fill the table, then overflow it
    for (int i = 0; i < SLOTS + 1; i++)
      rows.push_back('{mk(KIND_ADD, 16'(32'h0100 + i), 48'(20 + (i % 3)),
                          i[0] ? 32'd7 : 32'd0, 48'd0), 0, '0});
    rows.push_back('{mk(KIND_ADD, 16'h0AAA, 0, 0, 0), 1, res(0, 0, 0, ST_FULL)});
    // the table is full; a tick yields sixteen results at most
    rows.push_back('{mk(KIND_TICK, 0, 0, 0, 48'd1000), 0, '0});

    foreach (rows[k]) begin
      if (rows[k].has_ref) begin
        it = rows[k].it;
        send_item(it);
        if (expected_q[$] != rows[k].ref_res) begin
          $error("directed row %0d: predictor disagrees with table", k);
          fail_count++;
        end
      end else begin
        send_item(rows[k].it);
      end
      idle_gap();
    end

    // random part in phases over several floor settings
    clock_now = 48'd1000;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: set_arm_floor(20'd0);
        1: set_arm_floor(20'hF4240);
        2: set_arm_floor(20'hFFFFF);
        3: set_arm_floor(20'd37);
        default: set_arm_floor(20'd100);
      endcase
      for (int n = 0; n < 20; n++) begin
        pick = $urandom_range(0, 19);
        it = '0;
        it.timer_id = (pick == 19) ? 16'($urandom) : 16'($urandom_range(0, 7));
        if ($urandom_range(0, 3) == 0) clock_now = clock_now + $urandom_range(0, 3000);
        it.now_time = clock_now;
        if (pick < 9) begin
          it.kind = KIND_ADD;
          it.deadline = ($urandom_range(0, 15) == 0) ? 48'({$urandom, $urandom}) :
                        clock_now + $urandom_range(0, 5000) - 200;
          it.interval = ($urandom_range(0, 2) == 0) ? 32'd0 :
                        ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 4000);
        end else if (pick < 13) begin
          it.kind = KIND_CANCEL;
        end else if (pick < 19) begin
          it.kind = KIND_TICK;
          if ($urandom_range(0, 15) == 0) it.now_time = 48'({$urandom, $urandom});
        end else begin
          it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
        end
        send_item(it);
        idle_gap();
      end
    end

    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) $display("PASS multi_timer_expiry_queue");
    else $display("FAIL multi_timer_expiry_queue");
    $finish;
  end

endmodule
